### rtl/assert_macros.svh
// Assertion helpers used by pspe_checker.sv.
// Both expect clk, and PSPE_ASSERT also arst_n, to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge outside reset.
`define PSPE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define PSPE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/pspe_pkg.sv
package pspe_pkg;

	localparam int MAX_ORDER     = 64;
	localparam int CORDIC_STAGES = 16;
	localparam int TAYLOR_TERMS  = 13;
	localparam int ORDER_W       = 7;
	localparam int IN_W          = 16;
	localparam int OUT_W         = 24;
	localparam int FRAC          = 28;
	localparam int Q_W           = 34;
	localparam int M_W           = 36;
	localparam int MAG_W         = 30;
	localparam int UQ_W          = 30;
	localparam int CF_W          = 32;
	localparam int CNT_W         = 5;
	localparam int OUT_SHIFT     = FRAC - 16;

	localparam logic [ORDER_W-1:0] ORDER_RESET = 7'd2;

	localparam logic signed [Q_W-1:0] ONE_Q        = 34'sd268435456;
	localparam logic signed [Q_W-1:0] KINV_Q       = 34'sd163008219;
	localparam logic signed [Q_W-1:0] HALF_TURN    = 34'sd2147483648;
	localparam logic signed [Q_W-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [IN_W-1:0] HYP_MAX     = 16'sd16384;
	localparam logic signed [IN_W-1:0] HYP_MIN     = -16'sd16384;
	localparam logic [32:0] V_SCALE                = 33'd6746518852;

	localparam logic signed [2*Q_W-1:0] RND_Q  = (2*Q_W)'(64'd1 << (FRAC - 1));
	localparam logic signed [M_W:0]     ORND_Q = (M_W+1)'(64'd1 << (OUT_SHIFT - 1));
	localparam logic signed [M_W:0]     SAT_HI = 37'sd8388607;
	localparam logic signed [M_W:0]     SAT_LO = -37'sd8388608;

	// Stage map: CORDIC, then three stages per series term, then four output stages.
	localparam int CARRY_LAST = CORDIC_STAGES + 3 * TAYLOR_TERMS;
	localparam int PIPE_LAST  = CARRY_LAST + 4;

	typedef struct packed {
		logic signed [UQ_W-1:0]  uq;
		logic [IN_W-1:0]         v;
		logic signed [Q_W-1:0]   cx;
		logic signed [Q_W-1:0]   cy;
		logic signed [Q_W-1:0]   cz;
		logic                    flip;
		logic signed [Q_W-1:0]   term;
		logic signed [Q_W-1:0]   ch;
		logic signed [Q_W-1:0]   sh;
		logic signed [M_W-1:0]   m;
		logic [MAG_W-1:0]        mag;
		logic [MAG_W-1:0]        q0;
		logic                    neg;
	} pspe_carry_t;

	typedef struct packed {
		logic                   busy;
		logic signed [CF_W-1:0] a;
		logic signed [CF_W-1:0] b;
	} pspe_coef_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
	} pspe_point_t;

	typedef enum logic [1:0] {
		C_DIV,
		C_FOLD,
		C_ROT,
		C_IDLE
	} pspe_coef_state_t;

	// Fixed-point product, rounded half up.
	function automatic logic signed [M_W-1:0] mulq(input logic signed [Q_W-1:0] a,
		input logic signed [Q_W-1:0] b);
		logic signed [2*Q_W-1:0] p;
		p = a * b;
		p = p + RND_Q;
		return p[M_W+FRAC-1:FRAC];
	endfunction

	// Round to Q8.16 and saturate.
	function automatic logic signed [OUT_W-1:0] out_field(input logic signed [M_W-1:0] q);
		logic signed [M_W:0] r;
		r = ((M_W+1)'(q) + ORND_Q) >>> OUT_SHIFT;
		if (r > SAT_HI) begin
			r = SAT_HI;
		end else if (r < SAT_LO) begin
			r = SAT_LO;
		end
		return r[OUT_W-1:0];
	endfunction

	// Arctangent steps as 32-bit phases, full turn = 2^32.
	function automatic logic signed [Q_W-1:0] atan_at(input logic [CNT_W-1:0] idx);
		logic signed [Q_W-1:0] r;
		case (idx)
			5'd0:    r = 34'sh020000000;
			5'd1:    r = 34'sh012E4051D;
			5'd2:    r = 34'sh009FB385B;
			5'd3:    r = 34'sh0051111D4;
			5'd4:    r = 34'sh0028B0D43;
			5'd5:    r = 34'sh00145D7E1;
			5'd6:    r = 34'sh000A2F61E;
			5'd7:    r = 34'sh000517C55;
			5'd8:    r = 34'sh00028BE53;
			5'd9:    r = 34'sh000145F2E;
			5'd10:   r = 34'sh0000A2F98;
			5'd11:   r = 34'sh0000517CC;
			5'd12:   r = 34'sh000028BE6;
			5'd13:   r = 34'sh0000145F3;
			5'd14:   r = 34'sh000000A2F9;
			5'd15:   r = 34'sh00000517C;
			5'd16:   r = 34'sh0000028BE;
			5'd17:   r = 34'sh00000145F;
			5'd18:   r = 34'sh000000A2F;
			5'd19:   r = 34'sh000000517;
			5'd20:   r = 34'sh00000028B;
			5'd21:   r = 34'sh000000145;
			5'd22:   r = 34'sh0000000A2;
			5'd23:   r = 34'sh000000051;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### rtl/pspe_ifs.sv
interface pspe_in_if import pspe_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic signed [IN_W-1:0] hyp_param;
	logic [IN_W-1:0]        angle_param;

	modport source (output valid, output hyp_param, output angle_param, input ready);
	modport sink (input valid, input hyp_param, input angle_param, output ready);
endinterface

interface pspe_out_if import pspe_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] x_coord;
	logic signed [OUT_W-1:0] y_coord;
	logic signed [OUT_W-1:0] z_coord;

	modport source (output valid, output x_coord, output y_coord, output z_coord,
		input ready);
	modport sink (input valid, input x_coord, input y_coord, input z_coord,
		output ready);
endinterface

interface pspe_cfg_if import pspe_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ORDER_W-1:0] surface_order;

	modport source (output valid, output surface_order, input ready);
	modport sink (input valid, input surface_order, output ready);
endinterface

### rtl/pspe_coef.sv
// Order register and coefficient unit: phase = 2^31 / n by restoring division,
// then an iterative CORDIC gives a = sin(pi/n), b = cos(pi/n).
module pspe_coef import pspe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pspe_cfg_if.sink   cfg,
	output pspe_coef_t coef
);

	localparam logic [CNT_W-1:0] DIV_FIRST = 5'd31;
	localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(CORDIC_STAGES - 1);

	pspe_coef_state_t st_q, st_d;
	logic [ORDER_W-1:0] order_q, n_eff;
	logic [CNT_W-1:0]   cnt_q;
	logic [ORDER_W-1:0] rem_q, rem_d;
	logic [ORDER_W:0]   rem_sh;
	logic               ge;
	logic               cfg_fire;
	logic [31:0]        quot_q;
	logic signed [Q_W-1:0] cx_q, cy_q, cz_q, cx_n, cy_n, cz_n, ph;
	logic               flip_q;
	logic signed [CF_W-1:0] a_q, b_q;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid & cfg.ready;

	always_comb begin
		if (order_q == '0) begin
			n_eff = ORDER_W'(1);
		end else if (int'(order_q) > MAX_ORDER) begin
			n_eff = ORDER_W'(MAX_ORDER);
		end else begin
			n_eff = order_q;
		end
		// Only bit 31 of the dividend 2^31 is set.
		rem_sh = {rem_q, (cnt_q == DIV_FIRST)};
		ge     = (rem_sh >= {1'b0, n_eff});
		rem_d  = ge ? ORDER_W'(rem_sh - {1'b0, n_eff}) : ORDER_W'(rem_sh);
	end

	always_comb begin
		ph = Q_W'(signed'(quot_q));
		if (cz_q >= 0) begin
			cx_n = cx_q - (cy_q >>> cnt_q);
			cy_n = cy_q + (cx_q >>> cnt_q);
			cz_n = cz_q - atan_at(cnt_q);
		end else begin
			cx_n = cx_q + (cy_q >>> cnt_q);
			cy_n = cy_q - (cx_q >>> cnt_q);
			cz_n = cz_q + atan_at(cnt_q);
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			C_DIV:   if (cnt_q == '0) st_d = C_FOLD;
			C_FOLD:  st_d = C_ROT;
			C_ROT:   if (cnt_q == ROT_LAST) st_d = C_IDLE;
			C_IDLE:  st_d = C_IDLE;
			default: st_d = C_IDLE;
		endcase
		if (cfg_fire) st_d = C_DIV;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= C_DIV;
			order_q <= ORDER_RESET;
			cnt_q   <= DIV_FIRST;
			rem_q   <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_fire) begin
				order_q <= cfg.surface_order;
				cnt_q   <= DIV_FIRST;
				rem_q   <= '0;
			end else begin
				case (st_q)
					C_DIV: begin
						rem_q <= rem_d;
						if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
					end
					C_FOLD: cnt_q <= '0;
					C_ROT:  if (cnt_q != ROT_LAST) cnt_q <= cnt_q + 1'b1;
					default: cnt_q <= cnt_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			C_DIV: quot_q <= {quot_q[30:0], ge};
			C_FOLD: begin
				cx_q <= KINV_Q;
				cy_q <= '0;
				// fold into the right half plane, negate the result later
				if (ph > QUARTER_TURN) begin
					cz_q   <= ph - HALF_TURN;
					flip_q <= 1'b1;
				end else if (ph < -QUARTER_TURN) begin
					cz_q   <= ph + HALF_TURN;
					flip_q <= 1'b1;
				end else begin
					cz_q   <= ph;
					flip_q <= 1'b0;
				end
			end
			C_ROT: begin
				cx_q <= cx_n;
				cy_q <= cy_n;
				cz_q <= cz_n;
				if (cnt_q == ROT_LAST) begin
					a_q <= flip_q ? CF_W'(-cy_n) : CF_W'(cy_n);
					b_q <= flip_q ? CF_W'(-cx_n) : CF_W'(cx_n);
				end
			end
			default: quot_q <= quot_q;
		endcase
	end

	assign coef.busy = (st_q != C_IDLE);
	assign coef.a    = a_q;
	assign coef.b    = b_q;

endmodule

### rtl/parametric_surface_point_eval_unit.sv
// Surface point evaluator: for each (u, v) item it returns one point (x, y, z) in
// signed Q8.16, saturated. u (Q1.14) is clamped to [-1, 1]; v is a fraction of a
// full turn. Fully pipelined: one item per cycle while the skid entry is empty and
// the coefficient unit is not busy. The depth comes from the entry register, the
// CORDIC rotation stages for sin/cos v, three stages per term of the 13-term
// cosh/sinh series, four product/rounding stages and the output register. The
// output register plus one skid entry keep input accepted while a result waits.
// After reset and after every surface_order write the coefficient unit builds
// sin(pi/n) and cos(pi/n) by division and CORDIC; input ready
// stays low during that time. Write surface_order only when no item is in flight.
module parametric_surface_point_eval_unit import pspe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	pspe_in_if.sink     point_in,
	pspe_out_if.source  point_out,
	pspe_cfg_if.sink    cfg
);

	pspe_coef_t  coef;
	logic        en, in_fire;
	pspe_carry_t c_in;
	pspe_carry_t carry_s [0:CARRY_LAST];
	logic        vld_s [0:PIPE_LAST];
	logic signed [IN_W-1:0] uc;
	logic signed [Q_W-1:0]  ph;
	logic signed [Q_W-1:0]  a34, b34;

	logic signed [Q_W-1:0] cv_f, sv_f, em_f;
	logic [49:0]           vp_f;
	logic signed [Q_W-1:0] sa_s1, cb_s1, bs_s1, ac_s1, che_s1, bu_s1, vr_s1, ch_s1, em_s1;
	logic signed [Q_W-1:0] x1_s2, x2_s2, t_s2, y1_s2, av_s2, bu_s2, ac_s2;
	logic signed [Q_W-1:0] y2_s3, y1_s3;
	logic signed [M_W-1:0] x_s3, z_s3;
	pspe_point_t           pt_s4;

	pspe_point_t out_q, skid_q;
	logic        out_v_q, skid_v_q;

	pspe_coef u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.coef   (coef)
	);

	// The whole pipeline holds while the skid entry is occupied.
	assign en             = ~skid_v_q;
	assign point_in.ready = ~skid_v_q & ~coef.busy;
	assign in_fire        = point_in.valid & point_in.ready;
	assign a34            = Q_W'(coef.a);
	assign b34            = Q_W'(coef.b);

	// Entry: clamp u, scale to Q.28, fold the v phase into [-pi/2, pi/2].
	always_comb begin
		c_in = '0;
		if (point_in.hyp_param > HYP_MAX) begin
			uc = HYP_MAX;
		end else if (point_in.hyp_param < HYP_MIN) begin
			uc = HYP_MIN;
		end else begin
			uc = point_in.hyp_param;
		end
		ph        = Q_W'(signed'({point_in.angle_param, 16'h0000}));
		c_in.uq   = UQ_W'(uc) <<< 14;
		c_in.v    = point_in.angle_param;
		c_in.cx   = KINV_Q;
		c_in.cy   = '0;
		c_in.term = ONE_Q;
		c_in.ch   = ONE_Q;
		c_in.sh   = '0;
		if (ph > QUARTER_TURN) begin
			c_in.cz   = ph - HALF_TURN;
			c_in.flip = 1'b1;
		end else if (ph < -QUARTER_TURN) begin
			c_in.cz   = ph + HALF_TURN;
			c_in.flip = 1'b1;
		end else begin
			c_in.cz   = ph;
			c_in.flip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) carry_s[0] <= c_in;
	end

	// Valid bits travel with the items; advance together with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= PIPE_LAST; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_fire;
			for (int i = 1; i <= PIPE_LAST; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// CORDIC rotation stages for cos v / sin v, one micro-rotation each.
	for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_cor
		pspe_carry_t c_nx;
		always_comb begin
			c_nx = carry_s[gi];
			if (carry_s[gi].cz >= 0) begin
				c_nx.cx = carry_s[gi].cx - (carry_s[gi].cy >>> gi);
				c_nx.cy = carry_s[gi].cy + (carry_s[gi].cx >>> gi);
				c_nx.cz = carry_s[gi].cz - atan_at(CNT_W'(gi));
			end else begin
				c_nx.cx = carry_s[gi].cx + (carry_s[gi].cy >>> gi);
				c_nx.cy = carry_s[gi].cy - (carry_s[gi].cx >>> gi);
				c_nx.cz = carry_s[gi].cz + atan_at(CNT_W'(gi));
			end
		end
		always_ff @(posedge clk) begin
			if (en) carry_s[gi+1] <= c_nx;
		end
	end

	// Series terms t_k = (t_{k-1} * u) / k, truncated toward zero. Each term:
	// product, reciprocal multiply, then one compare-and-correct step.
	for (genvar gk = 1; gk <= TAYLOR_TERMS; gk++) begin : g_tay
		localparam int BASE = CORDIC_STAGES + 3 * (gk - 1);
		localparam logic [32:0] RCP = 33'(64'h1_0000_0000 / gk);
		pspe_carry_t ca, cb, cc;
		logic [62:0] qp;
		logic [Q_W-1:0] rr;
		logic [MAG_W-1:0] qq;
		logic signed [Q_W-1:0] tt;

		always_comb begin
			ca   = carry_s[BASE];
			ca.m = mulq(carry_s[BASE].term, Q_W'(carry_s[BASE].uq));
		end

		always_comb begin
			cb     = carry_s[BASE+1];
			cb.neg = carry_s[BASE+1].m[M_W-1];
			cb.mag = cb.neg ? MAG_W'(-carry_s[BASE+1].m) : MAG_W'(carry_s[BASE+1].m);
			qp     = 63'(cb.mag) * 63'(RCP);
			cb.q0  = qp[32+MAG_W-1:32];
		end

		always_comb begin
			cc = carry_s[BASE+2];
			rr = Q_W'(carry_s[BASE+2].mag) - Q_W'(carry_s[BASE+2].q0) * Q_W'(gk);
			qq = (rr >= Q_W'(gk)) ? carry_s[BASE+2].q0 + 1'b1 : carry_s[BASE+2].q0;
			tt = carry_s[BASE+2].neg ? -signed'(Q_W'(qq)) : signed'(Q_W'(qq));
			cc.term = tt;
			if ((gk % 2) == 1) begin
				cc.sh = carry_s[BASE+2].sh + tt;
			end else begin
				cc.ch = carry_s[BASE+2].ch + tt;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				carry_s[BASE+1] <= ca;
				carry_s[BASE+2] <= cb;
				carry_s[BASE+3] <= cc;
			end
		end
	end

	// Output stage 1: undo the fold, e^-u = cosh - sinh, first products, v in radians.
	always_comb begin
		cv_f = carry_s[CARRY_LAST].flip ? -carry_s[CARRY_LAST].cx : carry_s[CARRY_LAST].cx;
		sv_f = carry_s[CARRY_LAST].flip ? -carry_s[CARRY_LAST].cy : carry_s[CARRY_LAST].cy;
		em_f = carry_s[CARRY_LAST].ch - carry_s[CARRY_LAST].sh;
		vp_f = 50'(carry_s[CARRY_LAST].v) * 50'(V_SCALE) + 50'(64'd1 << 17);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sa_s1  <= Q_W'(mulq(a34, sv_f));
			cb_s1  <= Q_W'(mulq(b34, cv_f));
			bs_s1  <= Q_W'(mulq(b34, sv_f));
			ac_s1  <= Q_W'(mulq(a34, cv_f));
			che_s1 <= Q_W'(mulq(carry_s[CARRY_LAST].ch, em_f));
			bu_s1  <= Q_W'(mulq(b34, Q_W'(carry_s[CARRY_LAST].uq)));
			vr_s1  <= signed'({2'b00, vp_f[49:18]});
			ch_s1  <= carry_s[CARRY_LAST].ch;
			em_s1  <= em_f;
		end
	end

	// Output stage 2: second-level products.
	always_ff @(posedge clk) begin
		if (en) begin
			x1_s2 <= Q_W'(mulq(ch_s1, sa_s1 - cb_s1));
			x2_s2 <= Q_W'(mulq(sa_s1, em_s1));
			t_s2  <= Q_W'(mulq(em_s1, che_s1 + ONE_Q));
			y1_s2 <= Q_W'(mulq(bs_s1, ch_s1));
			av_s2 <= Q_W'(mulq(a34, vr_s1));
			bu_s2 <= bu_s1;
			ac_s2 <= ac_s1;
		end
	end

	// Output stage 3: last product for y, differences for x and z.
	always_ff @(posedge clk) begin
		if (en) begin
			y2_s3 <= Q_W'(mulq(ac_s2, t_s2));
			y1_s3 <= y1_s2;
			x_s3  <= M_W'(x1_s2) - M_W'(x2_s2);
			z_s3  <= M_W'(bu_s2) - M_W'(av_s2);
		end
	end

	// Output stage 4: round to Q8.16 and saturate.
	always_ff @(posedge clk) begin
		if (en) begin
			pt_s4.x <= out_field(x_s3);
			pt_s4.y <= out_field(M_W'(y1_s3) - M_W'(y2_s3));
			pt_s4.z <= out_field(z_s3);
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || point_out.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= vld_s[PIPE_LAST];
			end
		end else if (vld_s[PIPE_LAST] && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || point_out.ready) begin
			out_q <= skid_v_q ? skid_q : pt_s4;
		end else if (vld_s[PIPE_LAST] && en) begin
			skid_q <= pt_s4;
		end
	end

	assign point_out.valid   = out_v_q;
	assign point_out.x_coord = out_q.x;
	assign point_out.y_coord = out_q.y;
	assign point_out.z_coord = out_q.z;

endmodule

### rtl/pspe_checker.sv
`include "assert_macros.svh"

module pspe_checker import pspe_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [OUT_W-1:0] out_x,
	input logic signed [OUT_W-1:0] out_y,
	input logic signed [OUT_W-1:0] out_z,
	input logic                    cfg_valid,
	input logic                    cfg_ready
);

	localparam int CAP   = PIPE_LAST + 3;
	localparam int CNT_W = $clog2(CAP + 1) + 1;

	logic [CNT_W-1:0] cnt_q;
	logic             in_fire, out_fire;

	assign in_fire  = in_valid & in_ready;
	assign out_fire = out_valid & out_ready;

	// Items accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(in_fire) - CNT_W'(out_fire);
		end
	end

	`PSPE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`PSPE_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_z), "stalled result changed")
	`PSPE_ASSERT(a_cfg_busy, cfg_valid && cfg_ready |=> !in_ready, "input taken while coefficients rebuild")
	`PSPE_ASSERT(a_no_phantom, out_valid |-> cnt_q != '0, "result without an accepted item")
	`PSPE_ASSERT_ALWAYS(a_depth, arst_n |-> cnt_q <= CNT_W'(CAP), "more items in flight than storage")

endmodule

bind parametric_surface_point_eval_unit pspe_checker u_pspe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (point_in.valid),
	.in_ready  (point_in.ready),
	.out_valid (point_out.valid),
	.out_ready (point_out.ready),
	.out_x     (point_out.x_coord),
	.out_y     (point_out.y_coord),
	.out_z     (point_out.z_coord),
	.cfg_valid (cfg.valid),
	.cfg_ready (cfg.ready)
);

### sim/parametric_surface_point_eval_checker.sv
module parametric_surface_point_eval_checker import pspe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic signed [IN_W-1:0] in_hyp,
	input  logic [IN_W-1:0] in_angle,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic signed [OUT_W-1:0] out_x,
	input  logic signed [OUT_W-1:0] out_y,
	input  logic signed [OUT_W-1:0] out_z,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [ORDER_W-1:0] cfg_order,
	output int          fail_count,
	output int          pending_points
);
	localparam int FR = 28;
	localparam longint ONE = 64'sd1 <<< FR;
	localparam longint KINV = 64'sd163008219;

	longint arc_step [24] = '{
		64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
		64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F,
		64'h00000A2F, 64'h00000517, 64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

	logic [ORDER_W-1:0] order_shadow;
	pspe_point_t        point_queue [$];

	function automatic longint fx_mul(longint a, longint b);
		return (a * b + (64'sd1 <<< (FR - 1))) >>> FR;
	endfunction

	function automatic void rotate(logic [31:0] phase, output longint c, output longint s);
		longint z, x, y, dx, dy;
		bit flip;
		z = phase < 32'h80000000 ? longint'(phase) : longint'(phase) - (64'sd1 <<< 32);
		flip = 0;
		x = KINV;
		y = 0;
		if (z > (64'sd1 <<< 30)) begin
			z -= 64'sd1 <<< 31; flip = 1;
		end else if (z < -(64'sd1 <<< 30)) begin
			z += 64'sd1 <<< 31; flip = 1;
		end
		for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
			dx = y >>> i; dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= arc_step[i];
			end else begin
				x += dx; y -= dy; z += arc_step[i];
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		c = x; s = y;
	endfunction

	function automatic logic signed [OUT_W-1:0] to_q816(longint q);
		longint r;
		r = (q + (64'sd1 <<< (FR - 17))) >>> (FR - 16);
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return r[OUT_W-1:0];
	endfunction

	function automatic pspe_point_t eval_point(logic signed [IN_W-1:0] hyp,
		logic [IN_W-1:0] ang, logic [ORDER_W-1:0] ord);
		longint u, n, a, b, cv, sv, uq, term, ch, sh, em, sa, cb, x, y, z, t, vrad;
		logic [31:0] ph;
		pspe_point_t p;
		u = hyp;
		if (u > 16384) u = 16384;
		if (u < -16384) u = -16384;
		n = ord;
		if (n < 1) n = 1;
		if (n > MAX_ORDER) n = MAX_ORDER;
		ph = 32'h80000000 / 32'(n);
		rotate(ph, b, a);
		rotate({ang, 16'h0}, cv, sv);
		uq = u * (64'sd1 <<< (FR - 14));
		term = ONE; ch = ONE; sh = 0;
		for (int k = 1; k <= TAYLOR_TERMS; k++) begin
			term = fx_mul(term, uq) / k;
			if (k % 2) sh += term;
			else ch += term;
		end
		em = ch - sh;
		sa = fx_mul(a, sv);
		cb = fx_mul(b, cv);
		x = fx_mul(ch, sa - cb) - fx_mul(sa, em);
		t = fx_mul(em, fx_mul(ch, em) + ONE);
		y = fx_mul(fx_mul(b, sv), ch) - fx_mul(fx_mul(a, cv), t);
		vrad = longint'((64'(ang) * 64'd6746518852 + 64'd131072) >> 18);
		z = fx_mul(b, uq) - fx_mul(a, vrad);
		p.x = to_q816(x); p.y = to_q816(y); p.z = to_q816(z);
		return p;
	endfunction

	assign pending_points = point_queue.size();

	always @(posedge clk or negedge arst_n) begin
		pspe_point_t exp_pt;
		if (!arst_n) begin
			order_shadow <= ORDER_RESET;
			fail_count   <= 0;
			point_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) order_shadow <= cfg_order;
			if (in_valid && in_ready)
				point_queue.push_back(eval_point(in_hyp, in_angle, order_shadow));
			if (out_valid && out_ready) begin
				if (point_queue.size() == 0) begin
					$error("unexpected point x=%0d y=%0d z=%0d", out_x, out_y, out_z);
					fail_count <= fail_count + 1;
				end else begin
					exp_pt = point_queue.pop_front();
					if (exp_pt.x !== out_x || exp_pt.y !== out_y || exp_pt.z !== out_z)
						fail_count <= fail_count + 1;
					if (exp_pt.x !== out_x)
						$error("x_coord expected %0d actual %0d", exp_pt.x, out_x);
					if (exp_pt.y !== out_y)
						$error("y_coord expected %0d actual %0d", exp_pt.y, out_y);
					if (exp_pt.z !== out_z)
						$error("z_coord expected %0d actual %0d", exp_pt.z, out_z);
				end
			end
		end
	end
endmodule

### sim/parametric_surface_point_eval_unit_test.sv
module parametric_surface_point_eval_unit_test;
	import pspe_pkg::*;

	localparam int RANDOM_POINTS = 1830;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 120;

	logic clk = 0;
	logic arst_n = 0;
	int   cycle_count = 0;
	int   fail_count;
	int   pending_points;
	bit   calm_tail = 0;

	pspe_in_if  point_in ();
	pspe_out_if point_out ();
	pspe_cfg_if cfg ();

	parametric_surface_point_eval_unit dut (
		.clk(clk), .arst_n(arst_n),
		.point_in(point_in.sink), .point_out(point_out.source), .cfg(cfg.sink));

	parametric_surface_point_eval_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(point_in.valid), .in_ready(point_in.ready),
		.in_hyp(point_in.hyp_param), .in_angle(point_in.angle_param),
		.out_valid(point_out.valid), .out_ready(point_out.ready),
		.out_x(point_out.x_coord), .out_y(point_out.y_coord), .out_z(point_out.z_coord),
		.cfg_valid(cfg.valid), .cfg_ready(cfg.ready), .cfg_order(cfg.surface_order),
		.fail_count(fail_count), .pending_points(pending_points));

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Bail out if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		point_in.valid = 0;
		point_in.hyp_param = '0;
		point_in.angle_param = '0;
		cfg.valid = 0;
		cfg.surface_order = ORDER_RESET;
		point_out.ready = 0;
	end

	// Output stalls: random bursts of backpressure, none in the calm tail.
	initial begin
		int burst;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!calm_tail && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 18);
				point_out.ready <= 0;
				repeat (burst) @(negedge clk);
			end
			point_out.ready <= 1;
		end
	end

	// Offer one item and hold it until the block takes it.
	task automatic send_point(logic signed [IN_W-1:0] hyp, logic [IN_W-1:0] ang);
		int gap;
		if (!calm_tail && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			point_in.valid <= 0;
			repeat (gap) @(negedge clk);
		end
		point_in.valid <= 1;
		point_in.hyp_param <= hyp;
		point_in.angle_param <= ang;
		do @(posedge clk); while (!point_in.ready);
		@(negedge clk);
	endtask

	// Wait for every point to arrive, then let the coefficient unit settle.
	task automatic drain_points();
		point_in.valid <= 0;
		while (pending_points != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_order(logic [ORDER_W-1:0] ord);
		drain_points();
		cfg.valid <= 1;
		cfg.surface_order <= ord;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 0;
	endtask

	// Mostly in-range u, with a share of out-of-range values to hit the clamp.
	function automatic logic signed [IN_W-1:0] pick_hyp();
		if ($urandom_range(0, 9) == 0) return IN_W'($urandom());
		return IN_W'($urandom_range(0, 32768) - 16384);
	endfunction

	function automatic logic [ORDER_W-1:0] ORDER_WIDTH_RAND();
		return ORDER_W'($urandom());
	endfunction

	initial begin
		logic [ORDER_W-1:0] orders [8] = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd3, 7'd65, 7'd2, 7'd17};
		logic signed [IN_W-1:0] hyp_edges [7] = '{16'sd16384, -16'sd16384, 16'sd0,
			16'sd32767, -16'sd32768, 16'sd16385, -16'sd16385};
		logic [IN_W-1:0] ang_edges [5] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000};
		int per_phase;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: field extremes under the reset order, then orders 0 and 127, including clamped u.
		for (int i = 0; i < 7; i++) send_point(hyp_edges[i], ang_edges[i % 5]);
		send_point(16'sh5555, 16'hAAAA);
		send_point(-16'sh2AAB, 16'h5555);
		write_order(7'd0);
		for (int i = 0; i < 5; i++) send_point(hyp_edges[i], ang_edges[i]);
		write_order(7'd127);
		for (int i = 0; i < 5; i++) send_point(hyp_edges[i], ang_edges[4 - i]);

		// Random phases across several orders, extremes included.
		per_phase = RANDOM_POINTS / 9;
		for (int ph = 0; ph < 9; ph++) begin
			write_order(ph < 8 ? orders[ph] : ORDER_WIDTH_RAND());
			if (ph == 8) calm_tail = 1;
			for (int i = 0; i < per_phase; i++) send_point(pick_hyp(), IN_W'($urandom()));
		end

		drain_points();
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
